[rtl/sfd_pkg.sv]
// Types, symbol codes and register indexes shared by the SLIP frame decoder.
package sfd_pkg;

  localparam int LENGTH_BITS = 12;
  localparam int WAIT_BITS   = 16;
  localparam int CFG_BITS    = 16;

  localparam logic [7:0] SYM_END      = 8'hC0;
  localparam logic [7:0] SYM_ESC      = 8'hDB;
  localparam logic [7:0] SYM_ESC_END  = 8'hDC;
  localparam logic [7:0] SYM_ESC_ESC  = 8'hDD;
  localparam logic [7:0] SYM_ESC_ZERO = 8'hDE;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  localparam logic [1:0] REG_MAX_LENGTH  = 2'd0;
  localparam logic [1:0] REG_TIMEOUT     = 2'd1;
  localparam logic [1:0] REG_ZERO_ESCAPE = 2'd2;

  localparam logic [LENGTH_BITS-1:0] MAX_LENGTH_RESET = LENGTH_BITS'(1006);
  localparam logic [WAIT_BITS-1:0]   TIMEOUT_RESET    = WAIT_BITS'(1000);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_FRAME   = 2'd1,
    PH_ESCAPED = 2'd2
  } phase_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             data_byte;
    logic [LENGTH_BITS-1:0] packet_length;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    phase_t                 phase;
    logic [WAIT_BITS-1:0]   wait_count;
    logic [LENGTH_BITS-1:0] stored_count;
  } dec_state_t;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] max_length;
    logic [WAIT_BITS-1:0]   timeout_attempts;
    logic                   zero_escape;
  } cfg_t;

endpackage

[rtl/sfd_step.sv]
// Combinational decode of one receive attempt against the current decoder state.
module sfd_step import sfd_pkg::*; (
  input  dec_state_t state,
  input  cfg_t       cfg,
  input  in_item_t   item,
  output dec_state_t state_next,
  output logic       res_valid,
  output out_item_t  res
);

  logic [WAIT_BITS-1:0]   limit;
  logic [WAIT_BITS-1:0]   wait_inc;
  logic                   can_store;
  logic [LENGTH_BITS-1:0] stored_inc;

  assign limit      = (cfg.timeout_attempts < WAIT_BITS'(2)) ? WAIT_BITS'(1)
                                                           : cfg.timeout_attempts - WAIT_BITS'(1);
  assign wait_inc   = state.wait_count + WAIT_BITS'(1);
  assign can_store  = state.stored_count < cfg.max_length;
  assign stored_inc = state.stored_count + LENGTH_BITS'(1);

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res        = '0;
    unique case (state.phase)
      PH_FRAME: begin
        if (item.byte_valid) begin
          if (item.rx_byte == SYM_END) begin
            if (state.stored_count != '0) begin
              res_valid              = 1'b1;
              res.kind               = KIND_END;
              res.packet_length      = state.stored_count;
              res.last               = 1'b1;
              state_next.phase        = PH_HUNT;
              state_next.wait_count   = '0;
              state_next.stored_count = '0;
            end
          end else if (item.rx_byte == SYM_ESC) begin
            state_next.phase = PH_ESCAPED;
          end else if (can_store) begin
            res_valid               = 1'b1;
            res.kind                = KIND_DATA;
            res.data_byte           = item.rx_byte;
            state_next.stored_count = stored_inc;
          end
        end
      end
      PH_ESCAPED: begin
        if (item.byte_valid) begin
          state_next.phase = PH_FRAME;
          res.kind         = KIND_DATA;
          case (item.rx_byte)
            SYM_ESC_END:  res.data_byte = SYM_END;
            SYM_ESC_ESC:  res.data_byte = SYM_ESC;
            default:      res.data_byte = BYTE_ZERO;
          endcase
          if (can_store && (item.rx_byte == SYM_ESC_END || item.rx_byte == SYM_ESC_ESC ||
              (item.rx_byte == SYM_ESC_ZERO && cfg.zero_escape))) begin
            res_valid               = 1'b1;
            state_next.stored_count = stored_inc;
          end
        end
      end
      default: begin
        if (item.byte_valid && item.rx_byte == SYM_END) begin
          state_next.phase        = PH_FRAME;
          state_next.wait_count   = '0;
          state_next.stored_count = '0;
        end else begin
          state_next.phase = PH_HUNT;
          if (wait_inc >= limit) begin
            state_next.wait_count = '0;
            res_valid             = 1'b1;
            res.kind              = KIND_TIMEOUT;
            res.last              = 1'b1;
          end else begin
            state_next.wait_count = wait_inc;
          end
        end
      end
    endcase
  end

endmodule

[rtl/sfd_out_stage.sv]
// Result register that holds one decoded result until the downstream transfer.
module sfd_out_stage import sfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t load_item,
  output logic      slot_free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

endmodule

[rtl/slip_frame_decoder_core.sv]
// Top level of the SLIP frame decoder: input register, decoder state and result stage.
// An accepted attempt waits in the input register, and its decoded result is held in the result register.
// Throughput: one receive attempt per cycle while the result register has room; otherwise the attempt waits.
// The input register can refill in the same cycle that the result register is loaded.
// Synchronous reset returns to hunting with zero counts and the default register values.
module slip_frame_decoder_core import sfd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  logic       in_full;
  in_item_t   in_reg;
  dec_state_t state;
  dec_state_t state_next;
  cfg_t       cfg;
  logic       res_valid;
  out_item_t  res;
  logic       slot_free;
  logic       advance;

  assign advance  = in_full && slot_free;
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_HUNT, wait_count: '0, stored_count: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{max_length: MAX_LENGTH_RESET, timeout_attempts: TIMEOUT_RESET,
               zero_escape: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_LENGTH:  cfg.max_length       <= cfg_data[LENGTH_BITS-1:0];
        REG_TIMEOUT:     cfg.timeout_attempts <= cfg_data[WAIT_BITS-1:0];
        REG_ZERO_ESCAPE: cfg.zero_escape      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sfd_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (in_reg),
    .state_next (state_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .load_item (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Hunting always begins with an empty packet count.
  a_hunt_empty: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_HUNT |-> state.stored_count == '0)
    else $error("stored count not zero while hunting");

  // The hunt counter is cleared on entry to a frame and untouched inside it.
  a_frame_wait_clear: assert property (@(posedge clk) disable iff (rst)
    state.phase != PH_HUNT |-> state.wait_count == '0)
    else $error("wait count not zero inside a frame");

  // A produced result reaches the result register on the next edge.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid |=> out_valid && out_item == $past(res))
    else $error("result not loaded into the output register");

  // A held item waits in the input register until the result stage has room.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_full && !slot_free |=> in_full && $stable(in_reg) && $stable(state))
    else $error("input item or state changed while stalled");

endmodule

[tb/slip_frame_decoder_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the SLIP frame decoder core with a built-in decode predictor.
module slip_frame_decoder_core_tb import sfd_pkg::*;;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int CYCLE_LIMIT   = 300000;

  class slip_decode_board;
    cfg_t       cfg;
    dec_state_t st;
    out_item_t  decoded_items[$];
    int         failures;

    function new();
      cfg.max_length       = MAX_LENGTH_RESET;
      cfg.timeout_attempts = TIMEOUT_RESET;
      cfg.zero_escape      = 1'b0;
      st.phase             = PH_HUNT;
      st.wait_count        = '0;
      st.stored_count      = '0;
      failures             = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [CFG_BITS-1:0] val);
      case (idx)
        REG_MAX_LENGTH:  cfg.max_length = val[LENGTH_BITS-1:0];
        REG_TIMEOUT:     cfg.timeout_attempts = val[WAIT_BITS-1:0];
        REG_ZERO_ESCAPE: cfg.zero_escape = val[0];
        default: ;
      endcase
    endfunction

    function bit keep_byte(logic [7:0] b, ref out_item_t r);
      if (st.stored_count < cfg.max_length) begin
        st.stored_count = st.stored_count + LENGTH_BITS'(1);
        r.kind = KIND_DATA;
        r.data_byte = b;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Works out the result, if any, of one accepted receive attempt.
    function void take_attempt(in_item_t it);
      out_item_t            r;
      bit                   have;
      logic [WAIT_BITS-1:0] limit;
      r = '0;
      have = 1'b0;
      case (st.phase)
        PH_FRAME: if (it.byte_valid) begin
          if (it.rx_byte == SYM_END) begin
            if (st.stored_count != 0) begin
              r.kind = KIND_END;
              r.packet_length = st.stored_count;
              r.last = 1'b1;
              have = 1'b1;
              st.phase = PH_HUNT;
              st.wait_count = '0;
              st.stored_count = '0;
            end
          end else if (it.rx_byte == SYM_ESC) begin
            st.phase = PH_ESCAPED;
          end else begin
            have = keep_byte(it.rx_byte, r);
          end
        end
        PH_ESCAPED: if (it.byte_valid) begin
          st.phase = PH_FRAME;
          if (it.rx_byte == SYM_ESC_END) have = keep_byte(SYM_END, r);
          else if (it.rx_byte == SYM_ESC_ESC) have = keep_byte(SYM_ESC, r);
          else if (it.rx_byte == SYM_ESC_ZERO && cfg.zero_escape) have = keep_byte(BYTE_ZERO, r);
        end
        default: begin
          limit = (cfg.timeout_attempts < WAIT_BITS'(2)) ? WAIT_BITS'(1)
                                                         : cfg.timeout_attempts - WAIT_BITS'(1);
          st.wait_count = st.wait_count + WAIT_BITS'(1);
          if (it.byte_valid && it.rx_byte == SYM_END) begin
            st.phase = PH_FRAME;
            st.wait_count = '0;
            st.stored_count = '0;
          end else begin
            st.phase = PH_HUNT;
            if (st.wait_count >= limit) begin
              st.wait_count = '0;
              r.kind = KIND_TIMEOUT;
              r.last = 1'b1;
              have = 1'b1;
            end
          end
        end
      endcase
      if (have) decoded_items.push_back(r);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) flag($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
    endfunction

    function void compare_decoded(out_item_t got);
      out_item_t want;
      if (decoded_items.size() == 0) begin
        flag($sformatf("unexpected result: kind %0d data %02h length %0d last %0b",
                       got.kind, got.data_byte, got.packet_length, got.last));
        return;
      end
      want = decoded_items.pop_front();
      check_field("kind", 16'(want.kind), 16'(got.kind));
      check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
      check_field("packet_length", 16'(want.packet_length), 16'(got.packet_length));
      check_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = REG_MAX_LENGTH;
  logic [CFG_BITS-1:0] cfg_data = '0;

  slip_decode_board board = new();
  bit               steady = 1'b0;
  int               hold_asked = 0;
  int               hold_served = 0;
  int               hold_left = 0;
  int               attempts_sent = 0;
  int               cycle_count = 0;

  slip_frame_decoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: checks each transfer and stalls at random or for a requested stretch.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.compare_decoded(out_item);
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 28);
    end
  end

  task automatic send_attempt(input bit v, input logic [7:0] b, input bit counts = 1'b1);
    in_item_t it;
    it.byte_valid = v;
    it.rx_byte = b;
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    board.take_attempt(it);
    if (counts) attempts_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.decoded_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_register(idx, val);
  endtask

  task automatic configure(input int unsigned max_len, input int unsigned tmo, input bit zesc);
    put_reg(REG_MAX_LENGTH, CFG_BITS'(max_len));
    put_reg(REG_TIMEOUT, CFG_BITS'(tmo));
    put_reg(REG_ZERO_ESCAPE, CFG_BITS'(zesc));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] hot [0:6];
    hot = '{SYM_END, SYM_ESC, SYM_ESC_END, SYM_ESC_ESC, SYM_ESC_ZERO, BYTE_ZERO, 8'hFF};
    if ($urandom_range(0, 99) < 30) return hot[3'($urandom_range(0, 6))];
    return 8'($urandom_range(0, 255));
  endfunction

  // A well-formed frame with random content, now and then an empty attempt or a bad escape.
  task automatic send_frame();
    int         len;
    logic [7:0] d;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    send_attempt(1'b1, SYM_END);
    for (int i = 0; i < len; i++) begin
      d = pick_byte();
      if ($urandom_range(0, 9) == 0) send_attempt(1'b0, pick_byte(), 1'b0);
      if ($urandom_range(0, 19) == 0) begin
        send_attempt(1'b1, SYM_ESC);
        send_attempt(1'b1, pick_byte());
      end
      if (d == SYM_END) begin
        send_attempt(1'b1, SYM_ESC);
        send_attempt(1'b1, SYM_ESC_END);
      end else if (d == SYM_ESC) begin
        send_attempt(1'b1, SYM_ESC);
        send_attempt(1'b1, SYM_ESC_ESC);
      end else if (d == BYTE_ZERO && board.cfg.zero_escape && $urandom_range(0, 1)) begin
        send_attempt(1'b1, SYM_ESC);
        send_attempt(1'b1, SYM_ESC_ZERO);
      end else begin
        send_attempt(1'b1, d);
      end
    end
    send_attempt(1'b1, SYM_END);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_attempt($urandom_range(0, 99) < 80, pick_byte());
  endtask

  task automatic run_random(input int n, input int frame_pct);
    int target;
    target = attempts_sent + n;
    while (attempts_sent < target) begin
      if ($urandom_range(0, 99) < frame_pct) send_frame();
      else send_noise();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Default registers: hunt, empty END, empty attempts, every escape form, then a packet.
    send_attempt(1'b0, 8'hA5);
    send_attempt(1'b1, SYM_END);
    send_attempt(1'b1, SYM_END);
    send_attempt(1'b0, SYM_END);
    send_attempt(1'b1, 8'h00);
    send_attempt(1'b1, 8'hFF);
    send_attempt(1'b1, SYM_ESC);
    send_attempt(1'b0, SYM_ESC_END);
    send_attempt(1'b1, SYM_ESC_END);
    send_attempt(1'b1, SYM_ESC);
    send_attempt(1'b1, SYM_ESC_ESC);
    send_attempt(1'b1, SYM_ESC);
    send_attempt(1'b1, SYM_ESC_ZERO);
    send_attempt(1'b1, SYM_ESC);
    send_attempt(1'b1, SYM_END);
    send_attempt(1'b1, SYM_ESC);
    send_attempt(1'b1, SYM_ESC);
    send_attempt(1'b1, SYM_END);
    send_attempt(1'b1, 8'h55);
    send_attempt(1'b0, 8'h00);
    send_attempt(1'b1, 8'h7F);
    settle();

    // The timeout is lowered below the running hunt count, and the length limit is tiny.
    configure(2, 3, 1'b1);
    send_attempt(1'b1, SYM_ESC);
    send_attempt(1'b1, SYM_END);
    send_attempt(1'b1, SYM_ESC);
    send_attempt(1'b1, SYM_ESC_ZERO);
    send_attempt(1'b1, 8'h80);
    send_attempt(1'b1, 8'h7F);
    send_attempt(1'b1, SYM_END);
    settle();

    configure(0, 0, 1'b0);
    send_attempt(1'b0, SYM_END);
    send_attempt(1'b1, SYM_END);
    send_attempt(1'b1, 8'h33);
    send_attempt(1'b1, SYM_END);
    settle();

    configure(4095, 1, 1'b1);
    send_attempt(1'b1, 8'h44);
    send_attempt(1'b1, SYM_END);
    send_attempt(1'b0, 8'h00);
    settle();

    configure(1006, 65535, 1'b1);
    run_random(80, 85);
    steady = 1'b1;
    run_random(80, 85);
    steady = 1'b0;
    settle();

    configure($urandom_range(1, 8), $urandom_range(4, 40), 1'b0);
    hold_asked++;
    run_random(160, 50);
    settle();

    configure(4095, 2, 1'b1);
    run_random(140, 70);
    settle();

    configure($urandom_range(1, 4095), $urandom_range(2, 30), 1'($urandom_range(0, 1)));
    run_random(160, 65);
    settle();

    if (board.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
